// File: design/multi_stack_shared_buffer_defines.svh
// Assertion macros for the multi-stack shared buffer.
// Depends on nothing. The including module supplies the clock and reset signals.
`ifndef MULTI_STACK_SHARED_BUFFER_DEFINES_SVH
`define MULTI_STACK_SHARED_BUFFER_DEFINES_SVH

// Check a condition in the same cycle as its trigger.
`define MSSB_ASSERT_NOW(label, trig, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cond)) \
      else $error(msg);

// Check a condition a fixed number of cycles after its trigger.
`define MSSB_ASSERT_DELAY(label, trig, dly, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) \
      (trig) |-> ##(dly) (cond)) else $error(msg);

`endif

// File: design/mssb_pkg.sv
// Shared types and codes for the multi-stack shared buffer.
// Depends on nothing. Used by the controller, the datapath and the top level.
package mssb_pkg;

   localparam int STACK_ID_W = 3;
   localparam int VALUE_W    = 32;
   localparam int STATUS_W   = 2;

   // Item actions
   localparam logic ACTION_PUSH = 1'b0;
   localparam logic ACTION_POP  = 1'b1;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_RSVD  = 2'd3;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;    // capture the item and read the head pointer
      logic fetch;   // read link and element at the chosen slot
      logic commit;  // write back pointers and data, issue the result
   } mssb_cmd_type;

endpackage

// File: design/mssb_ctrl.sv
// Sequencer for the multi-stack shared buffer: accept, read, write back.
// Depends on mssb_pkg for the command struct.
module mssb_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   output mssb_pkg::mssb_cmd_type cmd
);
   import mssb_pkg::*;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_READ  = 2'd1;
   localparam logic [1:0] S_WRITE = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   // Advance through the three phases of one item
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) state_in = S_READ;
         end
         S_READ:  state_in = S_WRITE;
         S_WRITE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Drive commands from the current phase
   assign busy       = (state_ff != S_IDLE);
   assign cmd.load   = start && (state_ff == S_IDLE);
   assign cmd.fetch  = (state_ff == S_READ);
   assign cmd.commit = (state_ff == S_WRITE);

endmodule

// File: design/mssb_datapath.sv
// Datapath of the multi-stack shared buffer: head, link and element memories,
// free-list head, fill count and result registers. Depends on mssb_pkg.
module mssb_datapath #(
   parameter int NUM_STACKS = 8,
   parameter int CAPACITY   = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  mssb_pkg::mssb_cmd_type               cmd,
   input  logic                                 req_action,
   input  logic [mssb_pkg::STACK_ID_W-1:0]      req_stack_id,
   input  logic signed [mssb_pkg::VALUE_W-1:0]  req_value,
   output logic                                 rsp_valid,
   output logic [mssb_pkg::STATUS_W-1:0]        rsp_status,
   output logic signed [mssb_pkg::VALUE_W-1:0]  rsp_popped_value
);
   import mssb_pkg::*;

   localparam int PTR_W = $clog2(CAPACITY + 1);
   localparam int AW    = $clog2(CAPACITY);
   localparam int SW    = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
   localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(CAPACITY);

   // Memories: element data, links, stack heads
   logic [VALUE_W-1:0] elem_mem [CAPACITY];
   logic [PTR_W-1:0]   link_mem [CAPACITY];
   logic [PTR_W-1:0]   head_mem [NUM_STACKS];

   // Control state
   logic [NUM_STACKS-1:0] head_vld_ff;
   logic [PTR_W-1:0]      free_head_ff;
   logic [PTR_W-1:0]      fill_ff;
   logic                  rsp_valid_ff;

   // Item registers
   logic               action_ff;
   logic               sid_ok_ff;
   logic [SW-1:0]      sid_idx_ff;
   logic [VALUE_W-1:0] value_ff;
   logic [PTR_W-1:0]   head_rd_ff;
   logic               head_hit_ff;
   logic [PTR_W-1:0]   slot_ff;
   logic [PTR_W-1:0]   link_rd_ff;
   logic [VALUE_W-1:0] elem_rd_ff;
   logic               fresh_ff;
   logic [STATUS_W-1:0] status_ff;
   logic [VALUE_W-1:0]  popped_ff;

   logic [SW+STACK_ID_W-1:0] sid_wide;
   logic [SW-1:0]            sid_idx;
   logic                     sid_ok;
   logic [PTR_W-1:0]         head_cur;
   logic [PTR_W-1:0]         slot;
   logic [AW-1:0]            slot_rd_idx;
   logic [AW-1:0]            slot_wr_idx;
   logic                     is_push;
   logic                     ok;
   logic [PTR_W-1:0]         link_val;

   // Decode the stack number
   assign sid_wide = (SW + STACK_ID_W)'(req_stack_id);
   assign sid_idx  = sid_wide[SW-1:0];
   assign sid_ok   = (32'(req_stack_id) < 32'(NUM_STACKS));

   // Pick the slot: free-list head on push, stack top on pop
   assign head_cur    = head_hit_ff ? head_rd_ff : NULL_PTR;
   assign is_push     = (action_ff == ACTION_PUSH);
   assign slot        = is_push ? free_head_ff : head_cur;
   assign slot_rd_idx = slot[AW-1:0];
   assign slot_wr_idx = slot_ff[AW-1:0];

   // Slots at or above the fill count were never written; their link is taken as the next slot
   assign ok       = sid_ok_ff && (slot_ff < NULL_PTR);
   assign link_val = fresh_ff ? (slot_ff + PTR_W'(1)) : link_rd_ff;

   // Capture the item, the chosen slot and the result status and popped value
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff  <= req_action;
         sid_ok_ff  <= sid_ok;
         sid_idx_ff <= sid_idx;
         value_ff   <= req_value;
      end
      if (cmd.fetch) begin
         slot_ff  <= slot;
         fresh_ff <= (slot >= fill_ff);
      end
      if (cmd.commit) begin
         if (ok) begin
            status_ff <= STATUS_DONE;
         end else begin
            status_ff <= is_push ? STATUS_FULL : STATUS_EMPTY;
         end
         popped_ff <= (!is_push && ok) ? elem_rd_ff : '0;
      end
   end

   // Memory reads and write-back
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         head_rd_ff  <= head_mem[sid_idx];
         head_hit_ff <= head_vld_ff[sid_idx];
      end
      if (cmd.fetch) begin
         link_rd_ff <= link_mem[slot_rd_idx];
         elem_rd_ff <= elem_mem[slot_rd_idx];
      end
      if (cmd.commit && ok) begin
         link_mem[slot_wr_idx] <= is_push ? head_cur : free_head_ff;
         head_mem[sid_idx_ff]  <= is_push ? slot_ff : link_val;
         if (is_push) elem_mem[slot_wr_idx] <= value_ff;
      end
   end

   // Free list, fill count, head valid bits and result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         head_vld_ff  <= '0;
         free_head_ff <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.commit;
         if (cmd.commit && ok) begin
            head_vld_ff[sid_idx_ff] <= 1'b1;
            free_head_ff <= is_push ? link_val : slot_ff;
            if (is_push && fresh_ff) fill_ff <= fill_ff + PTR_W'(1);
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_popped_value = popped_ff;

endmodule

// File: design/multi_stack_shared_buffer.sv
// Steps per item: head-memory read, then link and element reads at the chosen slot,
//   then a write-back to the memories, from which the result strobe is registered.
// Start is taken only while busy is low, so a new item waits until the write-back.
// Reset (synchronous): all stacks empty, the whole store free; start is taken next cycle.
// The receiver cannot stall; each result shows for exactly one cycle.
`include "multi_stack_shared_buffer_defines.svh"

module multi_stack_shared_buffer #(
   parameter int NUM_STACKS = 8,
   parameter int CAPACITY   = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic                                 req_action,
   input  logic [mssb_pkg::STACK_ID_W-1:0]      req_stack_id,
   input  logic signed [mssb_pkg::VALUE_W-1:0]  req_value,
   output logic                                 rsp_valid,
   output logic [mssb_pkg::STATUS_W-1:0]        rsp_status,
   output logic signed [mssb_pkg::VALUE_W-1:0]  rsp_popped_value
);
   import mssb_pkg::*;

   mssb_cmd_type cmd;

   // Sequence each item
   mssb_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   // Hold the stacks and free list
   mssb_datapath #(
      .NUM_STACKS (NUM_STACKS),
      .CAPACITY   (CAPACITY)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_action       (req_action),
      .req_stack_id     (req_stack_id),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_popped_value (rsp_popped_value)
   );

   // Every accepted item gives its result
   `MSSB_ASSERT_DELAY(a_accept_resp, start && !busy, 3, rsp_valid, "result missing")
   // A result appears only once the sequencer is back at rest, with a real code
   `MSSB_ASSERT_NOW(a_resp_idle, rsp_valid, !busy && (rsp_status != STATUS_RSVD), "bad result")
   // A result never appears without an item in flight the cycle before
   `MSSB_ASSERT_NOW(a_resp_cause, rsp_valid, $past(busy), "spurious result")

endmodule
